>>> rtl/core/mfbp_pkg.sv
// ----------------------------------------------------------------------------
// mfbp_pkg
// Shared types and constants for the MSB-first bit packer.
// ----------------------------------------------------------------------------
package mfbp_pkg;

    localparam int unsigned BYTE_BITS = 8;
    localparam logic [7:0]  PAD_VALUE = 8'h00;
    localparam logic [3:0]  FREE_EMPTY = 4'd8;

    typedef enum logic
    {
        FUNC_APPEND = 1'b0,
        FUNC_ALIGN  = 1'b1
    } func_t;

    // one input transaction as held in the input register
    typedef struct packed
    {
        func_t      func;
        logic [7:0] data_bits;
        logic [3:0] bit_count;
    } item_t;

    // one result transaction
    typedef struct packed
    {
        logic [7:0] out_byte;
        logic [2:0] pad_bits;
    } result_t;

endpackage

>>> rtl/core/mfbp_in_reg.sv
// ----------------------------------------------------------------------------
// mfbp_in_reg
// Input register: captures one transaction and holds it until the merge
// stage takes it.
// ----------------------------------------------------------------------------
module mfbp_in_reg
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_stall,
    input  mfbp_pkg::item_t in_item,
    input  logic            advance,
    output logic            item_valid,
    output mfbp_pkg::item_t item
);

    logic            valid_reg;
    logic            valid_next;
    mfbp_pkg::item_t item_reg;

    assign in_stall   = valid_reg && !advance;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (in_valid && !in_stall)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            item_reg <= in_item;
        end
    end

endmodule

>>> rtl/core/mfbp_merge.sv
// ----------------------------------------------------------------------------
// mfbp_merge
// Packing state and merge logic: appends the top bits of an item to the
// partial byte, completes bytes and flushes on alignment.
// ----------------------------------------------------------------------------
module mfbp_merge
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              align_enable,
    input  logic              item_valid,
    input  mfbp_pkg::item_t   item,
    input  logic              out_free,
    output logic              advance,
    output logic              res_valid,
    output mfbp_pkg::result_t result
);

    logic [7:0] pending_reg;
    logic [7:0] pending_next;
    logic [3:0] free_reg;
    logic [3:0] free_next;

    logic [3:0] count_sat;
    logic [7:0] data_masked;
    logic [7:0] merged;
    logic [3:0] rest;
    logic       flush;
    logic       fills;

    always_comb
    begin
        count_sat   = (item.bit_count > 4'd8) ? 4'd8 : item.bit_count;
        data_masked = item.data_bits & ~(8'hFF >> count_sat);
        // free_reg stays in 1..8, so the shift is 0..7
        merged      = pending_reg | (data_masked >> (4'd8 - free_reg));
        rest        = count_sat - free_reg;
        flush       = (item.func == mfbp_pkg::FUNC_ALIGN) && align_enable
                      && (free_reg != mfbp_pkg::FREE_EMPTY);
        fills       = (item.func == mfbp_pkg::FUNC_APPEND) && (count_sat != 4'd0)
                      && (count_sat >= free_reg);

        res_valid = item_valid && (flush || fills);
        advance   = item_valid && (!(flush || fills) || out_free);

        result.out_byte = flush ? pending_reg : merged;
        result.pad_bits = flush ? free_reg[2:0] : 3'd0;

        pending_next = pending_reg;
        free_next    = free_reg;
        if (flush)
        begin
            pending_next = mfbp_pkg::PAD_VALUE;
            free_next    = mfbp_pkg::FREE_EMPTY;
        end
        else if (fills)
        begin
            // leftover bits move to the top of the fresh byte
            pending_next = data_masked << free_reg;
            free_next    = mfbp_pkg::FREE_EMPTY - rest;
        end
        else if (item.func == mfbp_pkg::FUNC_APPEND)
        begin
            pending_next = merged;
            free_next    = free_reg - count_sat;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= mfbp_pkg::PAD_VALUE;
            free_reg    <= mfbp_pkg::FREE_EMPTY;
        end
        else if (advance)
        begin
            pending_reg <= pending_next;
            free_reg    <= free_next;
        end
    end

    a_free_range: assert property (@(posedge clk) disable iff (!rst_n)
        (free_reg != 4'd0) && (free_reg <= mfbp_pkg::FREE_EMPTY))
        else $error("free bit count out of range");

    a_unwritten_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (pending_reg & ~(8'hFF << free_reg)) == 8'h00)
        else $error("unwritten bits of partial byte not zero");

    a_flush_empties: assert property (@(posedge clk) disable iff (!rst_n)
        advance && flush |=> (free_reg == mfbp_pkg::FREE_EMPTY)
                             && (pending_reg == mfbp_pkg::PAD_VALUE))
        else $error("align flush did not empty the partial byte");

endmodule

>>> rtl/core/mfbp_out_reg.sv
// ----------------------------------------------------------------------------
// mfbp_out_reg
// Result register: holds a finished byte until the sink takes it.
// ----------------------------------------------------------------------------
module mfbp_out_reg
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  mfbp_pkg::result_t result,
    output logic              out_free,
    output logic              out_valid,
    input  logic              out_stall,
    output mfbp_pkg::result_t out_result
);

    logic              valid_reg;
    logic              valid_next;
    mfbp_pkg::result_t result_reg;

    assign out_free   = !valid_reg || !out_stall;
    assign out_valid  = valid_reg;
    assign out_result = result_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            result_reg <= result;
        end
    end

endmodule

>>> rtl/core/msb_first_bit_packer.sv
// ----------------------------------------------------------------------------
// msb_first_bit_packer
// Packs 0..8 bit fields MSB first into bytes; align requests flush a
// partial byte with zero padding when enabled.
// ----------------------------------------------------------------------------
//  channel | handshake              | payload
//  --------+------------------------+------------------------------------
//  input   | in_valid / in_stall    | func, data_bits, bit_count
//  result  | out_valid / out_stall  | out_byte, pad_bits
//  config  | cfg_valid / cfg_ready  | cfg_data (align_enable)
//
//  One transaction per cycle sustained while the result side does not stall;
//  an accepted input passes the input register, merge and result register.
//  The merge loop on the partial byte is closed by pending_reg and free_reg.
//  Reset: partial byte empty, align_enable set; cfg_ready is always high.
//  A stalled result holds; input keeps flowing until an item that completes
//  a byte reaches the merge stage, then in_stall rises.
// ----------------------------------------------------------------------------
module msb_first_bit_packer
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic       func,
    input  logic [7:0] data_bits,
    input  logic [3:0] bit_count,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] out_byte,
    output logic [2:0] pad_bits,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic       cfg_data
);

    logic              align_enable_reg;
    mfbp_pkg::item_t   in_item;
    mfbp_pkg::item_t   item;
    logic              item_valid;
    logic              advance;
    logic              out_free;
    logic              res_valid;
    mfbp_pkg::result_t result;
    mfbp_pkg::result_t out_result;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            align_enable_reg <= 1'b1;
        end
        else if (cfg_valid && cfg_ready)
        begin
            align_enable_reg <= cfg_data;
        end
    end

    assign in_item.func      = mfbp_pkg::func_t'(func);
    assign in_item.data_bits = data_bits;
    assign in_item.bit_count = bit_count;

    mfbp_in_reg u_in_reg
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_item    (in_item),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    mfbp_merge u_merge
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .align_enable (align_enable_reg),
        .item_valid   (item_valid),
        .item         (item),
        .out_free     (out_free),
        .advance      (advance),
        .res_valid    (res_valid),
        .result       (result)
    );

    mfbp_out_reg u_out_reg
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (advance && res_valid),
        .result     (result),
        .out_free   (out_free),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_result (out_result)
    );

    assign out_byte = out_result.out_byte;
    assign pad_bits = out_result.pad_bits;

endmodule
